[rtl/core/bitmap_area_average_downscale_top_assert.svh]
// Assertion macros for the bitmap area-average downscaler.
// Used by the top level only; needs nothing else.
`ifndef BITMAP_AREA_AVERAGE_DOWNSCALE_TOP_ASSERT_SVH
`define BITMAP_AREA_AVERAGE_DOWNSCALE_TOP_ASSERT_SVH

// same-cycle implication
`define BAADS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BAADS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/baads_pkg.sv]
// Shared constants for the bitmap area-average downscaler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package baads_pkg;
    localparam int MAX_SRC_W = 4096;
    localparam int MAX_SRC_H = 4096;
    localparam int MAX_DST_W = 512;
    localparam int ACC_W     = 25;
    localparam int MEM_AW    = 10;   // bank bit and column

    localparam logic [1:0] REG_SRC_W = 2'd0;
    localparam logic [1:0] REG_SRC_H = 2'd1;
    localparam logic [1:0] REG_DST_W = 2'd2;
    localparam logic [1:0] REG_DST_H = 2'd3;
endpackage
`default_nettype wire

[rtl/core/bitmap_area_average_downscale_top.sv]
// Channel      | Dir | Handshake                 | Payload
// source byte  | in  | i_in_valid / o_in_stall   | i_source_byte
// dest result  | out | o_out_valid / i_out_stall | o_dest_byte, o_row_end, o_frame_end,
//              |     |                           | o_config_error
// config       | in  | APB psel/penable/pwrite   | paddr, pwdata, prdata
// Each byte is accepted in S_IDLE, then each pixel passes S_MUL (multiply) and S_ADV
// (advance); a set pixel also passes S_RD for each of the four weights and S_WR for
// each nonzero one: each accumulator update is a read then a write on the row store,
// which has one read and one write port. A row that completes a destination row
// then passes S_ERD and S_EWR per destination pixel and S_OUT per destination byte,
// waiting in S_OUT while a result is held. After reset and after every register write
// a clearing pass sweeps all 1024 store entries; input is stalled during it. Reset is
// synchronous, active low. Output stall holds the result register; input is taken
// while a result waits, unless the configuration is invalid. Depends on baads_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_area_average_downscale_top_assert.svh"
module bitmap_area_average_downscale_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_source_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_dest_byte,
    output logic             o_row_end,
    output logic             o_frame_end,
    output logic             o_config_error,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_RD, S_WR, S_ADV, S_ERD, S_EWR, S_OUT
    } t_state;

    t_state r_state;
    logic [12:0] r_sw, r_sh, r_dh;
    logic [9:0]  r_dw;
    logic [10:0] r_col;
    logic [13:0] r_srow;
    logic [11:0] r_drow;
    logic [24:0] r_rbp, r_rstart;
    logic        r_bank;
    logic [7:0]  r_byte;
    logic [2:0]  r_k;
    logic [12:0] r_xs;
    logic [22:0] r_p0, r_xb;
    logic [8:0]  r_xd;
    logic [22:0] r_amt [4];
    logic [1:0]  r_j;
    logic [12:0] r_oy1, r_oy2;
    logic        r_comp;
    logic [6:0]  r_ej;
    logic [2:0]  r_ei;
    logic [7:0]  r_ebyte;
    logic [9:0]  r_clr;
    logic [25:0] r_thresh;
    logic        r_out_valid;
    logic [7:0]  r_dest_byte;
    logic        r_row_end, r_frame_end, r_cfg_err;

    logic [baads_pkg::ACC_W-1:0] r_mem [1 << baads_pkg::MEM_AW];
    logic [baads_pkg::ACC_W-1:0] r_rdata;

    logic        w_bad, w_cfg_wr, w_in_acc, w_out_acc, w_last_row, w_row_done;
    logic [13:0] w_sw_p7;
    logic [10:0] w_dw_p7;
    logic [10:0] w_rowbytes;
    logic [6:0]  w_nbytes;
    logic [25:0] w_rstop, w_bound;
    logic [22:0] w_p1, w_ox1, w_ox2;
    logic [22:0] n_p0;
    logic        w_pix;
    logic        w_we;
    logic [9:0]  w_waddr, w_raddr, w_acc_addr;
    logic [24:0] w_wdata;
    logic [9:0]  w_ex;
    logic        w_ebit;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_out_valid && !i_out_stall;

    always_comb begin
        case (paddr[3:2])
            baads_pkg::REG_SRC_W: prdata = {19'd0, r_sw};
            baads_pkg::REG_SRC_H: prdata = {19'd0, r_sh};
            baads_pkg::REG_DST_W: prdata = {22'd0, r_dw};
            baads_pkg::REG_DST_H: prdata = {19'd0, r_dh};
            default:              prdata = 32'd0;
        endcase
    end

    assign w_bad = (r_sw == 13'd0) || (r_sh == 13'd0) || (r_dw == 10'd0) ||
                   (r_dh == 13'd0) || ({3'd0, r_dw} > r_sw) || (r_dh > r_sh) ||
                   (r_sw > 13'(baads_pkg::MAX_SRC_W)) ||
                   (r_sh > 13'(baads_pkg::MAX_SRC_H)) ||
                   (r_dw > 10'(baads_pkg::MAX_DST_W));

    assign o_in_stall = (r_state != S_IDLE) || (w_bad && r_out_valid);

    assign w_sw_p7    = {1'b0, r_sw} + 14'd7;
    assign w_rowbytes = w_sw_p7[13:3];
    assign w_dw_p7    = {1'b0, r_dw} + 11'd7;
    assign w_nbytes   = w_dw_p7[9:3];
    assign w_last_row = ({1'b0, r_drow} + 13'd1) >= r_dh;
    assign w_row_done = (r_col + 11'd1) == w_rowbytes;

    // vertical overlap of the current source row
    assign w_rstop = {1'b0, r_rstart} + {13'd0, r_dh};
    assign w_bound = {1'b0, r_rbp} + {13'd0, r_sh};

    // horizontal overlap of the current pixel
    assign w_p1  = r_p0 + {13'd0, r_dw};
    assign w_ox1 = (w_p1 <= r_xb) ? {13'd0, r_dw} : (r_xb - r_p0);
    assign w_ox2 = (w_p1 <= r_xb) ? 23'd0 : (w_p1 - r_xb);
    assign n_p0  = w_p1;
    assign w_pix = r_byte[r_k] && (r_xs < r_sw);

    assign w_acc_addr = {r_j[1] ? ~r_bank : r_bank, r_j[0] ? r_xd + 9'd1 : r_xd};
    assign w_ex       = {r_ej, r_ei};
    assign w_ebit     = (w_ex < r_dw) && ({r_rdata, 1'b0} >= r_thresh);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_acc_addr;
        w_raddr = w_acc_addr;
        w_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
            end
            S_WR: begin
                w_we    = 1'b1;
                w_wdata = r_rdata + {2'd0, r_amt[r_j]};
            end
            S_ERD: w_raddr = {r_bank, r_ej[5:0], r_ei};
            S_EWR: begin
                w_we    = 1'b1;
                w_waddr = {r_bank, r_ej[5:0], r_ei};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_thresh <= {13'd0, r_sw} * {13'd0, r_sh};
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_sw        <= 13'd1;
            r_sh        <= 13'd1;
            r_dw        <= 10'd1;
            r_dh        <= 13'd1;
            r_col       <= '0;
            r_srow      <= '0;
            r_drow      <= '0;
            r_rbp       <= '0;
            r_rstart    <= '0;
            r_bank      <= 1'b0;
            r_xs        <= '0;
            r_p0        <= '0;
            r_xd        <= '0;
            r_xb        <= 23'd1;
            r_out_valid <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                baads_pkg::REG_SRC_W: r_sw <= pwdata[12:0];
                baads_pkg::REG_SRC_H: r_sh <= pwdata[12:0];
                baads_pkg::REG_DST_W: r_dw <= pwdata[9:0];
                baads_pkg::REG_DST_H: r_dh <= pwdata[12:0];
                default: ;
            endcase
            if (paddr[3:2] == baads_pkg::REG_SRC_W) begin
                r_xb <= {10'd0, pwdata[12:0]};
            end else begin
                r_xb <= {10'd0, r_sw};
            end
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_col    <= '0;
            r_srow   <= '0;
            r_drow   <= '0;
            r_rbp    <= '0;
            r_rstart <= '0;
            r_bank   <= 1'b0;
            r_xs     <= '0;
            r_p0     <= '0;
            r_xd     <= '0;
            if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end else begin
            if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 10'd1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                        r_xb    <= {10'd0, r_sw};
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_bad) begin
                            r_out_valid <= 1'b1;
                            r_dest_byte <= 8'd0;
                            r_row_end   <= 1'b0;
                            r_frame_end <= 1'b0;
                            r_cfg_err   <= 1'b1;
                        end else begin
                            r_byte <= i_source_byte;
                            r_k    <= '0;
                            r_comp <= w_rstop >= w_bound;
                            if (w_rstop <= w_bound) begin
                                r_oy1 <= r_dh;
                                r_oy2 <= '0;
                            end else if ({1'b0, r_rstart} < w_bound) begin
                                r_oy1 <= 13'(w_bound - {1'b0, r_rstart});
                                r_oy2 <= 13'(w_rstop - w_bound);
                            end else begin
                                r_oy1 <= '0;
                                r_oy2 <= r_dh;
                            end
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_amt[0] <= 23'(w_ox1 * r_oy1);
                    r_amt[1] <= 23'(w_ox2 * r_oy1);
                    r_amt[2] <= 23'(w_ox1 * r_oy2);
                    r_amt[3] <= 23'(w_ox2 * r_oy2);
                    r_j      <= '0;
                    r_state  <= w_pix ? S_RD : S_ADV;
                end
                S_RD: begin
                    // skip zero contributions
                    if (r_amt[r_j] != '0) begin
                        r_state <= S_WR;
                    end else if (r_j == 2'd3) begin
                        r_state <= S_ADV;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                S_WR: begin
                    r_j     <= r_j + 2'd1;
                    r_state <= (r_j == 2'd3) ? S_ADV : S_RD;
                end
                S_ADV: begin
                    r_p0 <= n_p0;
                    if (n_p0 >= r_xb) begin
                        r_xd <= r_xd + 9'd1;
                        r_xb <= r_xb + {10'd0, r_sw};
                    end
                    r_xs <= r_xs + 13'd1;
                    r_k  <= r_k + 3'd1;
                    if (r_k != 3'd7) begin
                        r_state <= S_MUL;
                    end else if (!w_row_done) begin
                        r_col   <= r_col + 11'd1;
                        r_state <= S_IDLE;
                    end else begin
                        // row ends: rewind the horizontal walk
                        r_col    <= '0;
                        r_srow   <= r_srow + 14'd1;
                        r_rstart <= 25'(w_rstop);
                        r_xs     <= '0;
                        r_p0     <= '0;
                        r_xd     <= '0;
                        r_xb     <= {10'd0, r_sw};
                        r_ej     <= '0;
                        r_ei     <= '0;
                        r_state  <= r_comp ? S_ERD : S_IDLE;
                    end
                end
                S_ERD: r_state <= S_EWR;
                S_EWR: begin
                    r_ebyte[r_ei] <= w_ebit;
                    r_ei          <= r_ei + 3'd1;
                    r_state       <= (r_ei == 3'd7) ? S_OUT : S_ERD;
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_dest_byte <= r_ebyte;
                        r_row_end   <= (r_ej + 7'd1) == w_nbytes;
                        r_frame_end <= ((r_ej + 7'd1) == w_nbytes) && w_last_row;
                        r_cfg_err   <= 1'b0;
                        r_ej        <= r_ej + 7'd1;
                        if ((r_ej + 7'd1) != w_nbytes) begin
                            r_state <= S_ERD;
                        end else begin
                            r_state <= S_IDLE;
                            if (w_last_row) begin
                                r_srow   <= '0;
                                r_drow   <= '0;
                                r_rbp    <= '0;
                                r_rstart <= '0;
                                r_bank   <= 1'b0;
                            end else begin
                                r_drow <= r_drow + 12'd1;
                                r_rbp  <= r_rbp + {12'd0, r_sh};
                                r_bank <= ~r_bank;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_dest_byte    = r_dest_byte;
    assign o_row_end      = r_row_end;
    assign o_frame_end    = r_frame_end;
    assign o_config_error = r_cfg_err;

    `BAADS_ASSERT_NEXT(a_good_byte_starts, i_clk, i_rst_n,
        w_in_acc && !w_bad && !w_cfg_wr, r_state == S_MUL, "accepted byte not processed")
    `BAADS_ASSERT_NEXT(a_out_loads, i_clk, i_rst_n,
        r_state == S_OUT && !r_out_valid && !w_cfg_wr, r_out_valid, "result not loaded")
    `BAADS_ASSERT_NOW(a_frame_end_row_end, i_clk, i_rst_n,
        r_out_valid && r_frame_end, r_row_end && !r_cfg_err, "frame end off a row end")
endmodule
`default_nettype wire
